>>> rtl/stereo_nco_tone_with_fade_ramp_assert.svh
// Assertion macros shared by the tone generator RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef STEREO_NCO_TONE_WITH_FADE_RAMP_ASSERT_SVH
`define STEREO_NCO_TONE_WITH_FADE_RAMP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SNCO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SNCO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/snco_pkg.sv
// Package for the stereo tone generator: constants, sequencer states and
// the quarter-wave sine table function. No dependencies.
package snco_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int STEP_W   = 31;
    localparam int VOL_W    = 17;
    localparam int GAIN_W   = 17;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 15;
    localparam int MUL_W    = 32;

    localparam logic [GAIN_W-1:0] GAIN_FULL       = 17'd65536;
    localparam logic [GAIN_W-1:0] FADE_STEP_RESET = 17'd149;
    localparam logic [MUL_W-1:0]  OUT_SCALE       = 32'd32000;
    localparam logic [MAG_W-1:0]  MAG_MAX         = 15'd32767;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_SG_L,
        ST_P_L,
        ST_SG_R,
        ST_P_R,
        ST_DONE
    } snco_state_t;

    // Quarter-wave entry j: integer Taylor series of the angle in Q30,
    // eight truncated correction terms, rounded to Q0.15 magnitude.
    function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned j,
                                                     input int unsigned addr_bits);
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        q    = 64'd1 << (addr_bits - 2);
        x    = (64'd1686629713 * 64'(j) + (q >> 1)) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[MAG_W-1:0];
    endfunction

endpackage

>>> rtl/snco_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on snco_pkg for the operand width.
module snco_mul (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [snco_pkg::MUL_W-1:0]    op_a,
    input  logic [snco_pkg::MUL_W-1:0]    op_b,
    output logic [2*snco_pkg::MUL_W-1:0]  prod
);

    logic [2*snco_pkg::MUL_W-1:0] prod_reg;

    // Hold the product when not issued so later states can read it.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/snco_sine_rom.sv
// Full-wave sine lookup folded onto a quarter-wave constant table,
// registered output. Depends on snco_pkg for the table function.
module snco_sine_rom #(
    parameter int SINE_ADDR_BITS = snco_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                          aclk,
    input  logic [SINE_ADDR_BITS-1:0]     addr,
    output logic [snco_pkg::MAG_W-1:0]    mag,
    output logic                          neg
);

    localparam int QLEN = 1 << (SINE_ADDR_BITS - 2);

    logic [snco_pkg::MAG_W-1:0] quarter [0:QLEN];
    logic [SINE_ADDR_BITS-2:0]  idx;
    logic [SINE_ADDR_BITS-2:0]  j_ext;
    logic [snco_pkg::MAG_W-1:0] mag_reg;
    logic                       neg_reg;

    for (genvar k = 0; k <= QLEN; k++) begin : g_tab
        assign quarter[k] = snco_pkg::quarter_sine(k, SINE_ADDR_BITS);
    end

    // Odd quadrants run the quarter table backward.
    always_comb begin
        j_ext = {1'b0, addr[SINE_ADDR_BITS-3:0]};
        if (addr[SINE_ADDR_BITS-2]) begin
            idx = (SINE_ADDR_BITS-1)'(QLEN) - j_ext;
        end else begin
            idx = j_ext;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= quarter[idx];
        neg_reg <= addr[SINE_ADDR_BITS-1];
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

>>> rtl/stereo_nco_tone_with_fade_ramp.sv
// Top level of the stereo tone generator: sequencer, gain ramp, phase
// accumulators. Uses snco_pkg, snco_sine_rom, snco_mul and the assert header.
//
// Usage:
//   s_ channel: one item per audio sample tick. s_tdata carries both phase
//   increments and the volume, s_tuser carries the stop request.
//   m_ channel: one item per accepted tick with the left and right samples
//   in m_tdata and the faded-out flag in m_tuser.
//   cfg_we / cfg_wdata write the fade step (Q16 gain change per tick);
//   write it only while no item is in flight.
// Timing:
//   s_tready is high only while the sequencer is idle. An accepted item
//   walks six states in which the one shared 32x32 multiplier is issued
//   five times (volume times scale, then sine times gain and that times
//   the scaled volume, per channel), so the result is loaded into the
//   output register as the item leaves the last state, and a new item
//   can be taken only once the sequencer is back in idle.
// Stall:
//   the result sits in an output register; a finished item waits in the
//   last state until that register is free, and s_tready stays low meanwhile.
// Reset:
//   synchronous active-low aresetn clears both phases and the gain, sets the
//   fade step to 149 and empties the output register.
`include "stereo_nco_tone_with_fade_ramp_assert.svh"

module stereo_nco_tone_with_fade_ramp #(
    parameter int PHASE_BITS     = snco_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = snco_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [30:0] step_left, [61:31] step_right, [78:62] volume, [79] zero
    input  logic [79:0] s_tdata,
    // [0] stop_request
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] left_sample, [31:16] right_sample
    output logic [31:0] m_tdata,
    // [0] faded_out
    output logic [0:0]  m_tuser
);

    localparam int STEP_W = snco_pkg::STEP_W;
    localparam int GAIN_W = snco_pkg::GAIN_W;
    localparam int MUL_W  = snco_pkg::MUL_W;
    localparam int MAG_W  = snco_pkg::MAG_W;
    localparam int SMP_W  = snco_pkg::SAMPLE_W;
    localparam int SUM_W  = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

    snco_pkg::snco_state_t state_reg, state_next;

    logic [STEP_W-1:0]       step_l_reg, step_r_reg;
    logic [snco_pkg::VOL_W-1:0] vol_reg;
    logic                    stop_reg;
    logic [GAIN_W-1:0]       gain_reg, gain_next;
    logic [GAIN_W-1:0]       fade_step_reg;
    logic [PHASE_BITS-1:0]   phase_l_reg, phase_r_reg;
    logic [SUM_W-1:0]        sum_l, sum_r;
    logic [MUL_W-1:0]        vs_reg;
    logic                    neg_l_reg, neg_r_reg;
    logic [SMP_W-1:0]        left_reg;
    logic                    faded_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    accept;
    logic                    out_free;
    logic                    done_fire;
    logic [GAIN_W-1:0]       target;
    logic [GAIN_W-1:0]       diff;

    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic [MAG_W-1:0]        rom_mag;
    logic                    rom_neg;

    logic                    mul_en;
    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      mul_p;
    logic [SMP_W-1:0]        sample_now;

    // Scale the product down by 2^47, saturate, apply the sine sign.
    function automatic logic [15:0] make_sample(input logic [63:0] p, input logic neg);
        logic [14:0] m;
        logic [15:0] s;
        m = (p[63] | p[62]) ? snco_pkg::MAG_MAX : p[61:47];
        s = {1'b0, m};
        return neg ? (16'd0 - s) : s;
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == snco_pkg::ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign done_fire = (state_reg == snco_pkg::ST_DONE) && out_free;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            snco_pkg::ST_IDLE: if (s_tvalid) state_next = snco_pkg::ST_GAIN;
            snco_pkg::ST_GAIN: state_next = snco_pkg::ST_SG_L;
            snco_pkg::ST_SG_L: state_next = snco_pkg::ST_P_L;
            snco_pkg::ST_P_L:  state_next = snco_pkg::ST_SG_R;
            snco_pkg::ST_SG_R: state_next = snco_pkg::ST_P_R;
            snco_pkg::ST_P_R:  state_next = snco_pkg::ST_DONE;
            snco_pkg::ST_DONE: if (out_free) state_next = snco_pkg::ST_IDLE;
            default:           state_next = snco_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands per state.
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            snco_pkg::ST_GAIN: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(vol_reg);
                mul_b  = snco_pkg::OUT_SCALE;
            end
            snco_pkg::ST_SG_L, snco_pkg::ST_SG_R: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(rom_mag);
                mul_b  = MUL_W'(gain_reg);
            end
            snco_pkg::ST_P_L, snco_pkg::ST_P_R: begin
                mul_en = 1'b1;
                mul_a  = mul_p[MUL_W-1:0];
                mul_b  = vs_reg;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Left phase is looked up during the gain state, right phase after.
    assign rom_addr = (state_reg == snco_pkg::ST_GAIN) ?
                      phase_l_reg[PHASE_BITS-1 -: SINE_ADDR_BITS] :
                      phase_r_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];

    snco_sine_rom #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS)
    ) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .mag  (rom_mag),
        .neg  (rom_neg)
    );

    snco_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign sample_now = make_sample(mul_p, (state_reg == snco_pkg::ST_SG_R) ?
                                           neg_l_reg : neg_r_reg);

    // ---------------- gain ramp ----------------
    always_comb begin
        target    = stop_reg ? '0 : snco_pkg::GAIN_FULL;
        diff      = '0;
        gain_next = gain_reg;
        if (gain_reg < target) begin
            diff      = target - gain_reg;
            gain_next = (diff > fade_step_reg) ? gain_reg + fade_step_reg : target;
        end else if (gain_reg > target) begin
            diff      = gain_reg - target;
            gain_next = (diff > fade_step_reg) ? gain_reg - fade_step_reg : target;
        end
    end

    assign sum_l = SUM_W'(phase_l_reg) + SUM_W'(step_l_reg);
    assign sum_r = SUM_W'(phase_r_reg) + SUM_W'(step_r_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= snco_pkg::ST_IDLE;
            gain_reg      <= '0;
            fade_step_reg <= snco_pkg::FADE_STEP_RESET;
            phase_l_reg   <= '0;
            phase_r_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                fade_step_reg <= cfg_wdata;
            end
            if (state_reg == snco_pkg::ST_GAIN) begin
                gain_reg <= gain_next;
            end
            if (done_fire) begin
                phase_l_reg <= sum_l[PHASE_BITS-1:0];
                phase_r_reg <= sum_r[PHASE_BITS-1:0];
            end
            if (done_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            step_l_reg <= s_tdata[30:0];
            step_r_reg <= s_tdata[61:31];
            vol_reg    <= s_tdata[78:62];
            stop_reg   <= s_tuser[0];
        end
        if (state_reg == snco_pkg::ST_GAIN) begin
            faded_reg <= stop_reg && (gain_next == '0);
        end
        if (state_reg == snco_pkg::ST_SG_L) begin
            vs_reg    <= mul_p[MUL_W-1:0];
            neg_l_reg <= rom_neg;
        end
        if (state_reg == snco_pkg::ST_SG_R) begin
            left_reg  <= sample_now;
            neg_r_reg <= rom_neg;
        end
        if (done_fire) begin
            m_tdata_reg <= {sample_now, left_reg};
            m_tuser_reg <= faded_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // ---------------- assertions ----------------
    `SNCO_ASSERT_IMP(a_gain_bound, 1'b1, gain_reg <= snco_pkg::GAIN_FULL,
                     "gain above full scale")
    `SNCO_ASSERT_NXT(a_accept_starts, accept, state_reg == snco_pkg::ST_GAIN,
                     "accepted item did not start the sequence")
    `SNCO_ASSERT_NXT(a_done_presents, done_fire, m_tvalid && s_tready,
                     "finished item not presented on the output")
    `SNCO_ASSERT_IMP(a_busy_not_ready, state_reg != snco_pkg::ST_IDLE, !s_tready,
                     "input ready while the sequencer is busy")

endmodule

>>> dv/stereo_nco_tone_with_fade_ramp_tb.sv
// Self-checking testbench for stereo_nco_tone_with_fade_ramp: a directed table of ticks,
// then random ticks under several fade steps, checked against an in-bench tone predictor.
// Depends only on the RTL of the block.
module stereo_nco_tone_with_fade_ramp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FULL_GAIN   = 65536;
    localparam int FADE_RESET  = 149;
    localparam int QUARTER     = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        faded;
    } tone_out_t;

    typedef struct packed {
        logic        cfg_wr;
        logic [16:0] cfg_val;
        logic        stop;
        logic [16:0] vol;
        logic [30:0] step_l;
        logic [30:0] step_r;
        logic        typed;
        logic [15:0] exp_l;
        logic [15:0] exp_r;
        logic        exp_f;
    } tick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [16:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // tone predictor state
    logic [14:0] qsine [0:QUARTER];
    logic [31:0] phase_l_now;
    logic [31:0] phase_r_now;
    int          gain_now;
    int          fade_now;

    tone_out_t   expected_q [$];
    tone_out_t   want;
    tick_row_t   tick_rows [0:19];
    int          mismatches   = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          src_pct      = 30;
    int          sink_pct     = 30;
    int          sink_hold    = 0;

    stereo_nco_tone_with_fade_ramp dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Quarter-wave table: Taylor series of the Q30 angle, eight truncated terms.
    initial begin : sine_table
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        for (int j = 0; j <= QUARTER; j++) begin
            x    = (64'd1686629713 * 64'(j) + 64'd128) / 64'd256;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            qsine[j] = v[14:0];
        end
    end

    function automatic logic [15:0] scale_sample(input logic [31:0] ph, input logic [16:0] g,
                                                 input logic [16:0] vol);
        int          idx;
        logic [63:0] m;
        idx = int'(ph[29:22]);
        // odd quadrants read the table backwards
        if (ph[30]) begin
            idx = QUARTER - idx;
        end
        m = 64'(qsine[idx]) * 64'(g) * 64'(vol) * 64'd32000;
        m = m >> 47;
        if (m > 64'd32767) begin
            m = 64'd32767;
        end
        return ph[31] ? (16'd0 - m[15:0]) : m[15:0];
    endfunction

    // Ramp the gain, form both samples, then advance the phases.
    function automatic tone_out_t tone_tick(input logic [30:0] sl, input logic [30:0] sr,
                                            input logic [16:0] vol, input logic stop);
        tone_out_t res;
        int        target;
        target = stop ? 0 : FULL_GAIN;
        if (gain_now < target) begin
            gain_now = (target - gain_now > fade_now) ? gain_now + fade_now : target;
        end else if (gain_now > target) begin
            gain_now = (gain_now - target > fade_now) ? gain_now - fade_now : target;
        end
        res.left    = scale_sample(phase_l_now, 17'(gain_now), vol);
        res.right   = scale_sample(phase_r_now, 17'(gain_now), vol);
        res.faded   = stop && (gain_now == 0);
        phase_l_now = phase_l_now + {1'b0, sl};
        phase_r_now = phase_r_now + {1'b0, sr};
        return res;
    endfunction

    function automatic int idle_len(input int pct);
        if (int'($urandom_range(0, 99)) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return int'($urandom_range(10, 40));
        end
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [30:0] rand_step();
        case ($urandom_range(0, 9))
            0: begin
                return 31'd0;
            end
            1: begin
                return 31'h7FFF_FFFF;
            end
            2: begin
                return 31'($urandom_range(0, 65535));
            end
            3: begin
                // land on table entries, quarter points included
                return 31'($urandom_range(0, 511)) << 22;
            end
            default: begin
                return 31'($urandom);
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s", results_seen, what);
        end
    endtask

    task automatic send_tick(input logic [30:0] sl, input logic [30:0] sr,
                             input logic [16:0] vol, input logic stop,
                             input logic typed, input tone_out_t typed_exp);
        tone_out_t exp_out;
        int        gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, vol, sr, sl};
        s_tuser  <= stop;
        do @(posedge aclk); while (!s_tready);
        exp_out = tone_tick(sl, sr, vol, stop);
        if (typed) begin
            exp_out = typed_exp;
        end
        expected_q.push_back(exp_out);
        gap = idle_len(src_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait out every pending sample and the pipeline tail.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_fade(input logic [16:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        fade_now = int'(v);
    endtask

    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready  <= 1'b1;
            sink_hold <= idle_len(sink_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                flag_mismatch("sample with nothing expected");
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.left) begin
                    flag_mismatch($sformatf("left got %0d want %0d",
                                            $signed(m_tdata[15:0]), $signed(want.left)));
                end
                if (m_tdata[31:16] !== want.right) begin
                    flag_mismatch($sformatf("right got %0d want %0d",
                                            $signed(m_tdata[31:16]), $signed(want.right)));
                end
                if (m_tuser[0] !== want.faded) begin
                    flag_mismatch($sformatf("faded_out got %b want %b", m_tuser[0], want.faded));
                end
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stereo_nco_tone_with_fade_ramp_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic        stop_now;
        int          stop_left;
        logic [16:0] fade_val;
        logic [16:0] vol;
        stop_now  = 1'b0;
        stop_left = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        phase_l_now = '0;
        phase_r_now = '0;
        gain_now    = 0;
        fade_now    = FADE_RESET;

        // cfg_wr, cfg_val, stop, vol, step_l, step_r, typed, exp_l, exp_r, exp_f
        tick_rows = '{
            // stop straight out of reset: already faded
            '{1'b0, 17'd0, 1'b1, 17'd65536, 31'h0, 31'h0,
              1'b1, 16'h0, 16'h0, 1'b1},
            // first ramp tick, phase zero gives silence
            '{1'b0, 17'd0, 1'b0, 17'd131071, 31'h4000_0000, 31'h7FFF_FFFF,
              1'b1, 16'h0, 16'h0, 1'b0},
            // step above full scale: jump to full gain
            '{1'b1, 17'd131071, 1'b0, 17'd131071, 31'h4000_0000, 31'h1,
              1'b0, 16'h0, 16'h0, 1'b0},
            // half turn reads a zero entry
            '{1'b0, 17'd0, 1'b0, 17'd65536, 31'h4000_0000, 31'h4000_0000,
              1'b1, 16'h0, 16'h0, 1'b0},
            // negative peak with volume above full scale saturates
            '{1'b0, 17'd0, 1'b0, 17'd131071, 31'h7FFF_FFFF, 31'h0,
              1'b1, 16'h8001, 16'h8001, 1'b0},
            '{1'b1, 17'd65536, 1'b1, 17'd0, 31'h1, 31'h2AAA_AAAA,
              1'b1, 16'h0, 16'h0, 1'b1},
            // zero fade step: gain holds at zero
            '{1'b1, 17'd0, 1'b0, 17'd65536, 31'h1234_5678, 31'h7FFF_FFFF,
              1'b1, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b1, 17'd131071, 31'h0, 31'h0,
              1'b1, 16'h0, 16'h0, 1'b1},
            '{1'b1, 17'd1, 1'b0, 17'd65536, 31'h0100_0000, 31'h0040_0000,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b0, 17'd131071, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b1, 17'd149, 1'b0, 17'd65536, 31'h00A3_D70A, 31'h0147_AE14,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b1, 17'd65535, 1'b0, 17'd32768, 31'h1000_0000, 31'h3000_0000,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b1, 17'd65536, 31'h0555_5555, 31'h1555_5555,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b1, 17'd65536, 31'h0ABC_DEF0, 31'h1,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b1, 17'd32768, 1'b0, 17'd65537, 31'h2000_0000, 31'h6000_0000,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b0, 17'd65536, 31'h3FFF_FFFF, 31'h4000_0001,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b0, 17'd1, 31'h7FFF_FFFF, 31'h0,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b1, 17'd131071, 31'h2468_ACE0, 31'h1357_9BDF,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b1, 17'd65536, 31'h0040_0000, 31'h7FC0_0000,
              1'b0, 16'h0, 16'h0, 1'b0},
            '{1'b0, 17'd0, 1'b0, 17'd65536, 31'h0, 31'h0,
              1'b0, 16'h0, 16'h0, 1'b0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (tick_rows[k]) begin
            if (tick_rows[k].cfg_wr) begin
                write_fade(tick_rows[k].cfg_val);
            end
            send_tick(tick_rows[k].step_l, tick_rows[k].step_r, tick_rows[k].vol,
                      tick_rows[k].stop, tick_rows[k].typed,
                      {tick_rows[k].exp_l, tick_rows[k].exp_r, tick_rows[k].exp_f});
        end

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: fade_val = 17'd149;
                1: fade_val = 17'd1;
                2: fade_val = 17'd65536;
                3: fade_val = 17'd131071;
                4: fade_val = 17'd0;
                5: fade_val = 17'd4096;
                6: fade_val = 17'd65535;
                default: fade_val = 17'($urandom_range(2, 65534));
            endcase
            write_fade(fade_val);
            // one phase runs back to back on both sides
            src_pct  = (p == 2) ? 0 : 30;
            sink_pct = (p == 2) ? 0 : 30;
            for (int i = 0; i < 250; i++) begin
                // hold stop for runs long enough to reach both ends of the ramp
                if (stop_left == 0) begin
                    stop_now  = 1'($urandom_range(0, 1));
                    stop_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(300, 600))
                                                            : int'($urandom_range(1, 120));
                end
                stop_left--;
                case ($urandom_range(0, 9))
                    0: vol = 17'd0;
                    1: vol = 17'd65536;
                    2: vol = 17'($urandom_range(65537, 131071));
                    3: vol = 17'd131071;
                    default: vol = 17'($urandom_range(0, 65536));
                endcase
                send_tick(rand_step(), rand_step(), vol, stop_now, 1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("stereo_nco_tone_with_fade_ramp_tb passed");
        end else begin
            $display("stereo_nco_tone_with_fade_ramp_tb failed");
        end
        $finish;
    end

endmodule
